### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: opcodes,
// register indexes, field widths, controller states, command and status.
// ----------------------------------------------------------------------------
package bba_pkg;

    // field widths
    localparam int BS_W       = 13;
    localparam int BC_W       = 9;
    localparam int BYTES_W    = 21;
    localparam int OFS_W      = 20;
    localparam int NEED_W     = BYTES_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BS_W;

    // default capacity of the pool
    localparam int DEF_MAX_BLOCKS = 256;

    // register reset values
    localparam logic [BS_W-1:0] BS_RESET = 13'd64;
    localparam logic [BC_W-1:0] BC_RESET = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_NO_ROOM = 1'b1;

    // controller states
    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DIV_NEED = 8'b0000_0100,
        S_DIV_OFS = 8'b0000_1000,
        S_SCAN    = 8'b0001_0000,
        S_MARK    = 8'b0010_0000,
        S_FREE    = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic clr_step;
        logic div_load;
        logic sel_ofs;
        logic div_step;
        logic need_cap;
        logic first_cap;
        logic fail_set;
        logic scan_start;
        logic scan_step;
        logic found_cap;
        logic wr_step;
        logic res_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic is_free;
        logic need_big;
        logic scan_found;
        logic scan_fail;
        logic wr_act;
        logic out_free;
    } t_sts;

endpackage

### sv/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: configuration registers, shared restoring divider,
// in-use map memory, first-fit run scanner, run writer and result register.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_op,
    input  logic [BYTES_W-1:0]    i_bytes,
    input  logic [OFS_W-1:0]      i_offset,
    input  logic                  i_out_stall,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic                  o_status,
    output logic [OFS_W-1:0]      o_start_offset
);

    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int PW   = IW + BS_W;

    // configuration registers
    logic [BS_W-1:0] r_block_size;
    logic [BC_W-1:0] r_pool_blocks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BS_RESET;
            r_pool_blocks <= BC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_SIZE:  r_block_size  <= i_cfg_data;
                REG_BLOCK_COUNT: r_pool_blocks <= i_cfg_data[BC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective size and count, with zero and overflow clamped
    logic [BS_W-1:0] n_bs;
    logic [CNTW-1:0] n_cnt;

    always_comb begin
        n_bs = (r_block_size == '0) ? BS_W'(1) : r_block_size;
        if (r_pool_blocks == '0) begin
            n_cnt = CNTW'(1);
        end else if (32'(r_pool_blocks) > 32'(MAX_BLOCKS)) begin
            n_cnt = CNTW'(MAX_BLOCKS);
        end else begin
            n_cnt = CNTW'(r_pool_blocks);
        end
    end

    // request capture
    logic              r_op;
    logic [OFS_W-1:0]  r_offset;
    logic [BS_W-1:0]   r_bs;
    logic [CNTW-1:0]   r_cnt;
    logic              r_fail;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_op;
            r_offset <= i_offset;
            r_bs     <= n_bs;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (i_cmd.take) begin
            r_fail <= 1'b0;
        end else if (i_cmd.fail_set) begin
            r_fail <= 1'b1;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [BS_W-1:0]    r_rem;
    logic [BYTES_W-1:0] r_quo;
    logic [4:0]         r_div_cnt;
    logic [BS_W:0]      rem_sh;
    logic [BS_W:0]      rem_sub;
    logic               rem_ge;
    logic [BYTES_W-1:0] dividend;

    assign rem_sh  = {r_rem, r_quo[BYTES_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_bs};
    assign rem_sub = rem_sh - {1'b0, r_bs};

    // bytes minus one for the block count, a zero request counts as one block
    always_comb begin
        if (i_cmd.sel_ofs) begin
            dividend = {1'b0, r_offset};
        end else if (i_bytes == '0) begin
            dividend = '0;
        end else begin
            dividend = i_bytes - BYTES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= 5'(BYTES_W);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= dividend;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
            r_quo <= {r_quo[BYTES_W-2:0], rem_ge};
        end
    end

    // block count of the request
    logic [NEED_W-1:0] need_val;
    logic [NEED_W-1:0] r_need;

    assign need_val = {1'b0, r_quo} + NEED_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.need_cap) begin
            r_need <= need_val;
        end
    end

    // clearing pass index
    logic [IW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + IW'(1);
        end
    end

    // run writer: marks or clears one block per cycle
    logic [NEED_W-1:0] r_wr_idx;
    logic [NEED_W-1:0] r_wr_left;
    logic [CNTW-1:0]   scan_start_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.need_cap) begin
            r_wr_left <= need_val;
        end else if (i_cmd.wr_step) begin
            r_wr_left <= r_wr_left - NEED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.first_cap) begin
            r_wr_idx <= {1'b0, r_quo};
        end else if (i_cmd.found_cap) begin
            r_wr_idx <= NEED_W'(scan_start_idx);
        end else if (i_cmd.wr_step) begin
            r_wr_idx <= r_wr_idx + NEED_W'(1);
        end
    end

    // in-use map memory, one write and one registered read per cycle
    logic            r_map [MAX_BLOCKS];
    logic            r_rd_data;
    logic [CNTW-1:0] r_rd_idx;
    logic            map_we;
    logic [IW-1:0]   map_waddr;
    logic            map_wdata;

    assign map_we    = i_cmd.clr_step || i_cmd.wr_step;
    assign map_waddr = i_cmd.clr_step ? r_clr_idx : r_wr_idx[IW-1:0];
    assign map_wdata = i_cmd.clr_step ? 1'b0 : (r_op == OP_ALLOC);

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        r_rd_data <= r_map[r_rd_idx[IW-1:0]];
    end

    // first-fit scanner, reads issued every cycle, each evaluated from the registered read data
    logic            r_rd_vld;
    logic [CNTW-1:0] r_rd_pos;
    logic [CNTW-1:0] r_run;
    logic [CNTW-1:0] run_inc;
    logic            scan_hit;
    logic            scan_last;
    logic [IW-1:0]   r_start;

    assign run_inc        = r_run + CNTW'(1);
    assign scan_hit       = r_rd_vld && !r_rd_data && (run_inc == r_need[CNTW-1:0]);
    assign scan_last      = r_rd_pos == (r_cnt - CNTW'(1));
    assign scan_start_idx = r_rd_pos + CNTW'(1) - r_need[CNTW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_vld <= r_rd_idx < r_cnt;
        end else begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
            r_run    <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_rd_idx < r_cnt) begin
                r_rd_idx <= r_rd_idx + CNTW'(1);
                r_rd_pos <= r_rd_idx;
            end
            if (r_rd_vld) begin
                r_run <= r_rd_data ? '0 : run_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.found_cap) begin
            r_start <= scan_start_idx[IW-1:0];
        end
    end

    // byte offset of the run
    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(r_start) * PW'(r_bs);
    end

    // result register
    logic             r_out_vld;
    logic             r_out_status;
    logic [OFS_W-1:0] r_out_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= r_fail ? ST_NO_ROOM : ST_DONE;
            r_out_ofs    <= (r_op == OP_ALLOC && !r_fail) ? OFS_W'(r_prod) : '0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_start_offset = r_out_ofs;

    // status to controller
    always_comb begin
        o_sts.clr_last   = r_clr_idx == IW'(MAX_BLOCKS - 1);
        o_sts.div_done   = r_div_cnt == '0;
        o_sts.is_free    = r_op == OP_FREE;
        o_sts.need_big   = need_val > NEED_W'(r_cnt);
        o_sts.scan_found = scan_hit;
        o_sts.scan_fail  = r_rd_vld && !scan_hit && scan_last;
        o_sts.wr_act     = (r_wr_left != '0) && (r_wr_idx < NEED_W'(r_cnt));
        o_sts.out_free   = !r_out_vld || !i_out_stall;
    end

endmodule

### sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Allocator controller: sequences map clearing, the divisions, the scan,
// the run write and the result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take     = 1'b1;
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV_NEED;
                end
            end
            S_DIV_NEED: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.need_cap = 1'b1;
                    if (i_sts.is_free) begin
                        o_cmd.div_load = 1'b1;
                        o_cmd.sel_ofs  = 1'b1;
                        n_state        = S_DIV_OFS;
                    end else if (i_sts.need_big) begin
                        o_cmd.fail_set = 1'b1;
                        n_state        = S_RESULT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_DIV_OFS: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.first_cap = 1'b1;
                    n_state         = S_FREE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_found) begin
                    o_cmd.found_cap = 1'b1;
                    n_state         = S_MARK;
                end else if (i_sts.scan_fail) begin
                    o_cmd.fail_set = 1'b1;
                    n_state        = S_RESULT;
                end
            end
            S_MARK, S_FREE: begin
                if (i_sts.wr_act) begin
                    o_cmd.wr_step = 1'b1;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

### sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a pool of fixed-size blocks tracked by an
// in-use bitmap. Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// After reset the block clears the in-use map and
// accepts no request until that pass is over; configuration writes are taken
// at any time. Requests are handled one at a time. Each request first runs a
// restoring division for its block count (a free runs a second one for its
// starting block). An allocate then scans the map one bit per cycle from
// block 0 and marks the run one block per cycle; a free clears up to its
// block count one block per cycle. A new request is accepted while the last
// result still waits.
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [BYTES_W-1:0]    i_bytes,
    input  logic [OFS_W-1:0]      i_offset,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [OFS_W-1:0]      o_start_offset
);

    t_cmd cmd;
    t_sts sts;

    // sequencing
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // map, divider, scanner and result
    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_bytes        (i_bytes),
        .i_offset       (i_offset),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_start_offset (o_start_offset)
    );

endmodule
